[sv/bgi_pkg.sv]
// bgi_pkg: shared constants, codes and types for the bilinear grid interpolation block.
// Used by bgi_axis and bilinear_grid_interpolation; depends on nothing.
`default_nettype none
package bgi_pkg;

    localparam int MAX_X_POINTS_DEF = 64;
    localparam int MAX_Y_POINTS_DEF = 64;
    localparam int VALUE_WIDTH_DEF  = 32;

    localparam int CNT_W  = 7;
    localparam int FRAC_W = 17;
    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;
    localparam logic [CNT_W-1:0]  CNT_RESET = 7'd2;

    localparam logic [1:0] KIND_LOAD_X = 2'd0;
    localparam logic [1:0] KIND_LOAD_Y = 2'd1;
    localparam logic [1:0] KIND_LOAD_G = 2'd2;
    localparam logic [1:0] KIND_QUERY  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_LOADIDX = 2'd2;
    localparam logic [1:0] ST_DEGEN   = 2'd3;

    localparam logic REG_X_COUNT = 1'b0;
    localparam logic REG_Y_COUNT = 1'b1;

    // Result of one axis lookup
    typedef struct packed {
        logic              done;
        logic              range_err;
        logic              degen;
        logic [FRAC_W-1:0] frac;
    } axis_res_t;

endpackage
`default_nettype wire

[sv/bgi_axis.sv]
// bgi_axis: one breakpoint axis memory with segment scan and fraction divider.
// Depends on bgi_pkg.
`default_nettype none
module bgi_axis #(
    parameter int MAX_POINTS  = bgi_pkg::MAX_X_POINTS_DEF,
    parameter int VALUE_WIDTH = bgi_pkg::VALUE_WIDTH_DEF,
    localparam int IW = $clog2(MAX_POINTS),
    localparam int NW = IW + 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [IW-1:0]                 wr_addr,
    input  wire logic signed [VALUE_WIDTH-1:0] wr_data,
    input  wire logic                          start,
    input  wire logic [NW-1:0]                 n,
    input  wire logic signed [VALUE_WIDTH-1:0] query,
    output bgi_pkg::axis_res_t                 res,
    output logic [IW-1:0]                      seg
);
    import bgi_pkg::*;

    localparam int VW = VALUE_WIDTH;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SWAIT = 3'd2;
    localparam logic [2:0] S_LO    = 3'd3;
    localparam logic [2:0] S_HI    = 3'd4;
    localparam logic [2:0] S_PREP  = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic signed [VW-1:0] mem [MAX_POINTS];
    logic signed [VW-1:0] rd_data_reg;
    logic [IW-1:0]        rd_addr;

    logic [2:0]        st_reg, st_next;
    logic [IW-1:0]     k_reg, k_next;
    logic              pend_vld_reg, pend_vld_next;
    logic [IW-1:0]     pend_idx_reg, pend_idx_next;
    logic [IW-1:0]     seg_reg, seg_next;
    logic              err_reg, err_next;
    logic              degen_reg, degen_next;
    logic [4:0]        step_reg, step_next;
    logic signed [VW-1:0] q_reg, q_next;
    logic [NW-1:0]     n_reg, n_next;
    logic signed [VW-1:0] lo_reg, lo_next;
    logic [VW:0]       diff_reg, diff_next;
    logic [VW:0]       den_reg, den_next;
    logic [VW:0]       rem_reg, rem_next;
    logic [FRAC_W-1:0] quot_reg, quot_next;

    logic [VW+1:0] rem_sh;
    logic [VW+1:0] trial;

    // Synchronous axis memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        st_next       = st_reg;
        k_next        = k_reg;
        pend_vld_next = 1'b0;
        pend_idx_next = pend_idx_reg;
        seg_next      = seg_reg;
        err_next      = err_reg;
        degen_next    = degen_reg;
        step_next     = step_reg;
        q_next        = q_reg;
        n_next        = n_reg;
        lo_next       = lo_reg;
        diff_next     = diff_reg;
        den_next      = den_reg;
        rem_next      = rem_reg;
        quot_next     = quot_reg;
        rd_addr       = k_reg;
        rem_sh        = {rem_reg, ((step_reg == 5'd0) ? diff_reg[0] : 1'b0)};
        trial         = rem_sh - {1'b0, den_reg};

        // Check the breakpoint read back in the previous cycle
        if (pend_vld_reg)
        begin
            if ((pend_idx_reg == '0) && (q_reg < rd_data_reg))
            begin
                err_next = 1'b1;
            end
            if ((NW'(pend_idx_reg) == n_reg - NW'(1)) && (q_reg > rd_data_reg))
            begin
                err_next = 1'b1;
            end
            if ((NW'(pend_idx_reg) <= n_reg - NW'(2)) && (rd_data_reg <= q_reg))
            begin
                seg_next = pend_idx_reg;
            end
        end

        unique case (st_reg)
            S_IDLE, S_DONE:
            begin
                if (start)
                begin
                    q_next     = query;
                    n_next     = n;
                    k_next     = '0;
                    seg_next   = '0;
                    err_next   = 1'b0;
                    degen_next = 1'b0;
                    st_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                rd_addr       = k_reg;
                pend_vld_next = 1'b1;
                pend_idx_next = k_reg;
                if (NW'(k_reg) == n_reg - NW'(1))
                begin
                    st_next = S_SWAIT;
                end
                else
                begin
                    k_next = k_reg + IW'(1);
                end
            end
            S_SWAIT:
            begin
                st_next = S_LO;
            end
            S_LO:
            begin
                rd_addr = seg_reg;
                st_next = S_HI;
            end
            S_HI:
            begin
                rd_addr = seg_reg + IW'(1);
                lo_next = rd_data_reg;
                st_next = S_PREP;
            end
            S_PREP:
            begin
                den_next   = {rd_data_reg[VW-1], rd_data_reg} - {lo_reg[VW-1], lo_reg};
                diff_next  = {q_reg[VW-1], q_reg} - {lo_reg[VW-1], lo_reg};
                degen_next = (rd_data_reg <= lo_reg);
                step_next  = '0;
                quot_next  = '0;
                rem_next   = {1'b0, diff_next[VW:1]};
                if (err_reg || degen_next)
                begin
                    st_next = S_DONE;
                end
                else if ({1'b0, diff_next} >= {den_next, 1'b0})
                begin
                    // Quotient would be two or more: saturate
                    quot_next = FRAC_ONE;
                    st_next   = S_DONE;
                end
                else
                begin
                    st_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!trial[VW+1])
                begin
                    rem_next  = trial[VW:0];
                    quot_next = {quot_reg[FRAC_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh[VW:0];
                    quot_next = {quot_reg[FRAC_W-2:0], 1'b0};
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(FRAC_W - 1))
                begin
                    st_next = S_DONE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= S_IDLE;
            pend_vld_reg <= 1'b0;
        end
        else
        begin
            st_reg       <= st_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        pend_idx_reg <= pend_idx_next;
        seg_reg      <= seg_next;
        err_reg      <= err_next;
        degen_reg    <= degen_next;
        step_reg     <= step_next;
        q_reg        <= q_next;
        n_reg        <= n_next;
        lo_reg       <= lo_next;
        diff_reg     <= diff_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
    end

    assign res.done      = (st_reg == S_DONE);
    assign res.range_err = err_reg;
    assign res.degen     = degen_reg;
    assign res.frac      = (quot_reg > FRAC_ONE) ? FRAC_ONE : quot_reg;
    assign seg           = seg_reg;

endmodule
`default_nettype wire

[sv/bilinear_grid_interpolation.sv]
// Top level: bilinear lookup over a loaded grid with two breakpoint axes.
// Depends on bgi_pkg and bgi_axis.
//
// Usage:
//   s_axis carries one word per item; tuser holds the kind (load first-axis
//   point, load second-axis point, load grid value, query). Every word gives
//   exactly one result word on m_axis: tdata is the Q16.16 blend (zero for
//   loads and failed queries), tuser the status.
//   The cfg port sets the two breakpoint counts; write it only while idle.
// Timing:
//   A load is written to its memory at acceptance; the post state then
//   puts its result into the output register once that register is free.
//   A query scans both axis memories in parallel, one breakpoint a cycle,
//   then runs a 17-step restoring divide per axis and four grid reads
//   through a weight multiplier and a value multiplier. The scan over the
//   axis memory port and the bit-serial divider take most of a query.
// Reset clears the control and sets both counts to 2; memories hold garbage
// until loaded. When the receiver stalls the result is held in the output
// register and the next word is still taken; the block then waits at the
// end of that word until the output register frees.
`default_nettype none
module bilinear_grid_interpolation #(
    parameter int MAX_X_POINTS = bgi_pkg::MAX_X_POINTS_DEF,
    parameter int MAX_Y_POINTS = bgi_pkg::MAX_Y_POINTS_DEF,
    parameter int VALUE_WIDTH  = bgi_pkg::VALUE_WIDTH_DEF,
    localparam int XW     = $clog2(MAX_X_POINTS),
    localparam int YW     = $clog2(MAX_Y_POINTS),
    localparam int IN_DW  = ((XW + YW + 3 * VALUE_WIDTH + 7) / 8) * 8,
    localparam int OUT_DW = ((VALUE_WIDTH + 7) / 8) * 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // row_index, col_index, load_value, query_x, query_y (low bits first)
    input  wire logic [IN_DW-1:0]            s_axis_tdata,
    // kind
    input  wire logic [1:0]                  s_axis_tuser,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // interpolated
    output logic [OUT_DW-1:0]                m_axis_tdata,
    // status
    output logic [1:0]                       m_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_addr,
    input  wire logic [bgi_pkg::CNT_W-1:0]   cfg_wdata
);
    import bgi_pkg::*;

    localparam int VW    = VALUE_WIDTH;
    localparam int GAW   = $clog2(MAX_X_POINTS * MAX_Y_POINTS);
    localparam int WW    = 2 * FRAC_W;
    localparam int PW    = VW + WW + 1;
    localparam int AW    = PW + 2;

    localparam logic [2:0] T_IDLE = 3'd0;
    localparam logic [2:0] T_AXIS = 3'd1;
    localparam logic [2:0] T_GA   = 3'd2;
    localparam logic [2:0] T_GB   = 3'd3;
    localparam logic [2:0] T_GC   = 3'd4;
    localparam logic [2:0] T_POST = 3'd5;

    // Unpack the input word
    logic [XW-1:0]        row_index;
    logic [YW-1:0]        col_index;
    logic signed [VW-1:0] load_value;
    logic signed [VW-1:0] query_x;
    logic signed [VW-1:0] query_y;
    logic [1:0]           kind;

    assign row_index  = s_axis_tdata[XW-1:0];
    assign col_index  = s_axis_tdata[XW+YW-1:XW];
    assign load_value = s_axis_tdata[XW+YW +: VW];
    assign query_x    = s_axis_tdata[XW+YW+VW +: VW];
    assign query_y    = s_axis_tdata[XW+YW+2*VW +: VW];
    assign kind       = s_axis_tuser;

    logic [CNT_W-1:0] xcnt_reg, ycnt_reg;
    logic [XW:0]      nx;
    logic [YW:0]      ny;

    logic [2:0]        st_reg, st_next;
    logic [1:0]        status_reg, status_next;
    logic [1:0]        term_reg, term_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic [WW-1:0]     w_reg, w_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic              out_vld_reg, out_vld_next;
    logic [OUT_DW-1:0] out_data_reg, out_data_next;
    logic [1:0]        out_stat_reg, out_stat_next;

    logic accept;
    logic row_ok, col_ok;
    logic x_wr, y_wr, g_wr, ax_start;

    axis_res_t     xres, yres;
    logic [XW-1:0] xseg;
    logic [YW-1:0] yseg;

    logic signed [VW-1:0] grid_mem [MAX_X_POINTS * MAX_Y_POINTS];
    logic signed [VW-1:0] g_rd_reg;
    logic [GAW-1:0]       g_waddr, g_raddr;
    logic [XW-1:0]        g_row;
    logic [YW-1:0]        g_col;

    logic [FRAC_W-1:0] gx, gy, wa, wb;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xcnt_reg <= CNT_RESET;
            ycnt_reg <= CNT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == REG_X_COUNT)
            begin
                xcnt_reg <= cfg_wdata;
            end
            else
            begin
                ycnt_reg <= cfg_wdata;
            end
        end
    end

    // Clamp the counts to 2..max
    always_comb
    begin
        if (xcnt_reg < CNT_W'(2))
            nx = (XW+1)'(2);
        else if (32'(xcnt_reg) > 32'(MAX_X_POINTS))
            nx = (XW+1)'(MAX_X_POINTS);
        else
            nx = (XW+1)'(xcnt_reg);
        if (ycnt_reg < CNT_W'(2))
            ny = (YW+1)'(2);
        else if (32'(ycnt_reg) > 32'(MAX_Y_POINTS))
            ny = (YW+1)'(MAX_Y_POINTS);
        else
            ny = (YW+1)'(ycnt_reg);
    end

    assign s_axis_tready = (st_reg == T_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign row_ok        = ((XW+1)'(row_index) < nx);
    assign col_ok        = ((YW+1)'(col_index) < ny);
    assign x_wr          = accept && (kind == KIND_LOAD_X) && row_ok;
    assign y_wr          = accept && (kind == KIND_LOAD_Y) && col_ok;
    assign g_wr          = accept && (kind == KIND_LOAD_G) && row_ok && col_ok;
    assign ax_start      = accept && (kind == KIND_QUERY);

    bgi_axis #(
        .MAX_POINTS  (MAX_X_POINTS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_x_axis (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (x_wr),
        .wr_addr (row_index),
        .wr_data (load_value),
        .start   (ax_start),
        .n       (nx),
        .query   (query_x),
        .res     (xres),
        .seg     (xseg)
    );

    bgi_axis #(
        .MAX_POINTS  (MAX_Y_POINTS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_y_axis (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (y_wr),
        .wr_addr (col_index),
        .wr_data (load_value),
        .start   (ax_start),
        .n       (ny),
        .query   (query_y),
        .res     (yres),
        .seg     (yseg)
    );

    // Grid memory: row-major, row stride MAX_Y_POINTS
    assign g_waddr = GAW'(GAW'(row_index) * GAW'(MAX_Y_POINTS) + GAW'(col_index));
    assign g_row   = xseg + XW'(term_reg[1]);
    assign g_col   = yseg + YW'(term_reg[0]);
    assign g_raddr = GAW'(GAW'(g_row) * GAW'(MAX_Y_POINTS) + GAW'(g_col));

    always_ff @(posedge clk)
    begin
        if (g_wr)
        begin
            grid_mem[g_waddr] <= load_value;
        end
        g_rd_reg <= grid_mem[g_raddr];
    end

    // Corner weights: term bit 1 picks the upper row, bit 0 the upper column
    assign gx = FRAC_ONE - xres.frac;
    assign gy = FRAC_ONE - yres.frac;
    assign wa = term_reg[1] ? xres.frac : gx;
    assign wb = term_reg[0] ? yres.frac : gy;

    always_comb
    begin
        st_next       = st_reg;
        status_next   = status_reg;
        term_next     = term_reg;
        acc_next      = acc_reg;
        w_next        = w_reg;
        prod_next     = prod_reg;
        out_vld_next  = out_vld_reg;
        out_data_next = out_data_reg;
        out_stat_next = out_stat_reg;

        // Drop the output word once taken
        if (out_vld_reg && m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end

        unique case (st_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    acc_next    = '0;
                    term_next   = '0;
                    status_next = ST_OK;
                    priority case (kind)
                        KIND_LOAD_X:
                        begin
                            if (!row_ok) status_next = ST_LOADIDX;
                            st_next = T_POST;
                        end
                        KIND_LOAD_Y:
                        begin
                            if (!col_ok) status_next = ST_LOADIDX;
                            st_next = T_POST;
                        end
                        KIND_LOAD_G:
                        begin
                            if (!(row_ok && col_ok)) status_next = ST_LOADIDX;
                            st_next = T_POST;
                        end
                        default:
                        begin
                            st_next = T_AXIS;
                        end
                    endcase
                end
            end
            T_AXIS:
            begin
                if (xres.done && yres.done)
                begin
                    if (xres.range_err || yres.range_err)
                    begin
                        status_next = ST_RANGE;
                        st_next     = T_POST;
                    end
                    else if (xres.degen || yres.degen)
                    begin
                        status_next = ST_DEGEN;
                        st_next     = T_POST;
                    end
                    else
                    begin
                        st_next = T_GA;
                    end
                end
            end
            T_GA:
            begin
                // Grid read issued at g_raddr; form the weight product
                w_next  = {{FRAC_W{1'b0}}, wa} * {{FRAC_W{1'b0}}, wb};
                st_next = T_GB;
            end
            T_GB:
            begin
                prod_next = g_rd_reg * $signed({1'b0, w_reg});
                st_next   = T_GC;
            end
            T_GC:
            begin
                acc_next  = acc_reg + AW'(prod_reg);
                term_next = term_reg + 2'd1;
                if (term_reg == 2'd3)
                    st_next = T_POST;
                else
                    st_next = T_GA;
            end
            T_POST:
            begin
                if (!out_vld_reg || m_axis_tready)
                begin
                    out_vld_next  = 1'b1;
                    out_data_next = OUT_DW'(acc_reg[32 +: VW]);
                    out_stat_next = status_reg;
                    st_next       = T_IDLE;
                end
            end
            default:
            begin
                st_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= T_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        term_reg     <= term_next;
        acc_reg      <= acc_next;
        w_reg        <= w_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
        out_stat_reg <= out_stat_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_stat_reg;

`ifndef ASSERT_OFF
    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
        else $error("nonzero result with failing status");

    a_axes_done: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == T_GA) |-> (xres.done && yres.done))
        else $error("grid read before both axis lookups finished");

    a_no_err_blend: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == T_GA) |-> !(xres.range_err || yres.range_err || xres.degen || yres.degen))
        else $error("blend started on a failed lookup");

    a_post_free: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == T_POST) && out_vld_reg && !m_axis_tready |=> (st_reg == T_POST))
        else $error("result posted over an untaken word");
`endif

endmodule
`default_nettype wire
